@@ design/vmap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_pkg
// Types, constants and address helpers shared by the video memory access port.
// ----------------------------------------------------------------------------
package vmap_pkg;

  localparam int unsigned WordCount = 32768;
  localparam int unsigned PhysW     = $clog2(WordCount);
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CmdW      = 3;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 2;

  typedef enum logic [CmdW-1:0] {
    CmdAddrLo  = 3'd0,
    CmdAddrHi  = 3'd1,
    CmdWriteLo = 3'd2,
    CmdWriteHi = 3'd3,
    CmdReadLo  = 3'd4,
    CmdReadHi  = 3'd5
  } cmd_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStepSelect = 2'd0,
    CfgStepOnHigh = 2'd1,
    CfgRemapMode  = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RemapNone = 2'd0,
    RemapRot8 = 2'd1,
    RemapRot9 = 2'd2,
    RemapRot10 = 2'd3
  } remap_e;

  typedef enum logic [1:0] {
    StepOne     = 2'd0,
    StepRow     = 2'd1,
    StepBlock   = 2'd2,
    StepBlockAlt = 2'd3
  } step_e;

  typedef struct packed {
    logic             rd_en;
    logic             wr_lo;
    logic             wr_hi;
    logic [PhysW-1:0] addr;
    logic [ByteW-1:0] wdata;
  } mem_req_t;

  function automatic logic [PhysW-1:0] remap_addr(input logic [AddrW-1:0] a,
                                                   input remap_e mode);
    logic [PhysW-1:0] p;
    begin
      unique case (mode)
        RemapRot8:  p = {a[14:8], a[4:0], a[7:5]};
        RemapRot9:  p = {a[14:9], a[5:0], a[8:6]};
        RemapRot10: p = {a[14:10], a[6:0], a[9:7]};
        default:    p = a[PhysW-1:0];
      endcase
      return p;
    end
  endfunction

  function automatic logic [AddrW-1:0] step_size(input step_e sel);
    logic [AddrW-1:0] s;
    begin
      unique case (sel)
        StepOne: s = 16'd1;
        StepRow: s = 16'd32;
        default: s = 16'd128;
      endcase
      return s;
    end
  endfunction

endpackage

@@ design/vmap_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_if
// Handshake channels of the video memory access port: commands, read
// results and configuration writes.
// ----------------------------------------------------------------------------
interface vmap_cmd_if;
  logic                        valid;
  logic                        ready;
  logic [vmap_pkg::CmdW-1:0]   cmd;
  logic [vmap_pkg::ByteW-1:0]  data_byte;

  modport source (output valid, output cmd, output data_byte, input ready);
  modport sink   (input valid, input cmd, input data_byte, output ready);
endinterface

interface vmap_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [vmap_pkg::ByteW-1:0]  read_byte;

  modport source (output valid, output read_byte, input ready);
  modport sink   (input valid, input read_byte, output ready);
endinterface

interface vmap_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [vmap_pkg::CfgIdxW-1:0]  index;
  logic [vmap_pkg::CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/video_memory_access_port.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_memory_access_port
// Byte-wide command port into a 32768-word video memory with address and
// read-latch registers, remapping and configurable auto-increment.
// ----------------------------------------------------------------------------
// After reset the port zeroes the video memory, one word per cycle, and takes
// no command beats until that pass ends; configuration writes are taken at any
// time. Address-set, byte-write and unused commands load their result straight
// into the output register; a read first passes the memory's read register, as
// the memory returns its data in the cycle after the address. Every command
// beat produces exactly one result beat, zero except for reads. A finished
// result waits in an output register; a command beat is taken only with no
// read pending, and that register empty or emptied in the same cycle.
module video_memory_access_port (
  input  logic            clk_i,
  input  logic            rst_ni,
  vmap_cmd_if.sink        cmd_i,
  vmap_rsp_if.source      rsp_o,
  vmap_cfg_if.sink        cfg_i
);

  logic [vmap_pkg::AddrW-1:0] addr_q, addr_d;
  logic [vmap_pkg::AddrW-1:0] latch_q, latch_d;
  vmap_pkg::step_e            step_sel_q;
  logic                       step_hi_q;
  vmap_pkg::remap_e           remap_q;
  logic                       pend_q, pend_d;
  logic                       pend_hi_q, pend_hi_d;
  logic                       rsp_valid_q, rsp_valid_d;
  logic [vmap_pkg::ByteW-1:0] rsp_byte_q, rsp_byte_d;

  vmap_pkg::mem_req_t               mem_req;
  logic                             clr_busy;
  logic [2*vmap_pkg::ByteW-1:0]     rd_word;
  logic                             cmd_fire, rsp_fire, cfg_fire;
  vmap_pkg::cmd_e                   cmd;
  logic [vmap_pkg::AddrW-1:0]       step;

  vmap_vram u_vram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (mem_req),
    .clr_busy_o (clr_busy),
    .rd_word_o  (rd_word)
  );

  assign cmd_i.ready = !clr_busy && !pend_q && (!rsp_valid_q || rsp_o.ready);
  assign cmd_fire    = cmd_i.valid && cmd_i.ready;
  assign rsp_fire    = rsp_o.valid && rsp_o.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign cmd         = vmap_pkg::cmd_e'(cmd_i.cmd);
  assign step        = vmap_pkg::step_size(step_sel_q);

  assign rsp_o.valid     = rsp_valid_q;
  assign rsp_o.read_byte = rsp_byte_q;

  always_comb begin
    addr_d        = addr_q;
    latch_d       = latch_q;
    pend_d        = 1'b0;
    pend_hi_d     = pend_hi_q;
    rsp_valid_d   = rsp_valid_q && !rsp_fire;
    rsp_byte_d    = rsp_byte_q;
    mem_req.rd_en = 1'b0;
    mem_req.wr_lo = 1'b0;
    mem_req.wr_hi = 1'b0;
    mem_req.addr  = vmap_pkg::remap_addr(addr_q, remap_q);
    mem_req.wdata = cmd_i.data_byte;

    if (pend_q) begin
      rsp_valid_d = 1'b1;
      rsp_byte_d  = pend_hi_q ? rd_word[2*vmap_pkg::ByteW-1:vmap_pkg::ByteW]
                              : rd_word[vmap_pkg::ByteW-1:0];
    end

    if (cmd_fire) begin
      rsp_valid_d = 1'b1;
      rsp_byte_d  = '0;
      case (cmd)
        vmap_pkg::CmdAddrLo: begin
          addr_d  = {addr_q[15:8], cmd_i.data_byte};
          latch_d = {latch_q[15:8], cmd_i.data_byte};
        end
        vmap_pkg::CmdAddrHi: begin
          addr_d  = {cmd_i.data_byte, addr_q[7:0]};
          latch_d = {cmd_i.data_byte, latch_q[7:0]};
        end
        vmap_pkg::CmdWriteLo, vmap_pkg::CmdWriteHi: begin
          mem_req.wr_lo = (cmd == vmap_pkg::CmdWriteLo);
          mem_req.wr_hi = (cmd == vmap_pkg::CmdWriteHi);
          latch_d       = addr_q;
          if (step_hi_q == (cmd == vmap_pkg::CmdWriteHi)) begin
            addr_d = addr_q + step;
          end
        end
        vmap_pkg::CmdReadLo, vmap_pkg::CmdReadHi: begin
          mem_req.rd_en = 1'b1;
          mem_req.addr  = vmap_pkg::remap_addr(latch_q, remap_q);
          rsp_valid_d   = 1'b0;
          pend_d        = 1'b1;
          pend_hi_d     = (cmd == vmap_pkg::CmdReadHi);
          if (step_hi_q == (cmd == vmap_pkg::CmdReadHi)) begin
            latch_d = addr_q;
            addr_d  = addr_q + step;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      latch_q     <= '0;
      step_sel_q  <= vmap_pkg::StepOne;
      step_hi_q   <= 1'b0;
      remap_q     <= vmap_pkg::RemapNone;
      pend_q      <= 1'b0;
      pend_hi_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      addr_q      <= addr_d;
      latch_q     <= latch_d;
      pend_q      <= pend_d;
      pend_hi_q   <= pend_hi_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_fire) begin
        unique case (vmap_pkg::cfg_idx_e'(cfg_i.index))
          vmap_pkg::CfgStepSelect: step_sel_q <= vmap_pkg::step_e'(cfg_i.data);
          vmap_pkg::CfgStepOnHigh: step_hi_q  <= cfg_i.data[0];
          vmap_pkg::CfgRemapMode:  remap_q    <= vmap_pkg::remap_e'(cfg_i.data);
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_byte_q <= rsp_byte_d;
  end

`ifndef ASSERT_OFF
  a_no_cmd_during_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy |-> !cmd_i.ready)
    else $error("command taken during memory clearing pass");

  a_pend_slot_free : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !rsp_valid_q)
    else $error("read data arrives while the output register is occupied");

  a_read_completes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && (cmd == vmap_pkg::CmdReadLo || cmd == vmap_pkg::CmdReadHi))
      |=> pend_q ##1 rsp_valid_q)
    else $error("read beat did not produce a result two cycles later");

  a_other_completes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_fire && !(cmd == vmap_pkg::CmdReadLo || cmd == vmap_pkg::CmdReadHi))
      |=> rsp_valid_q && rsp_byte_q == '0)
    else $error("non-read beat did not produce a zero result");
`endif

endmodule

@@ design/vmap_vram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vmap_vram
// Video memory as two byte lanes with registered reads, and the
// clearing pass that zeroes every word after reset.
// ----------------------------------------------------------------------------
module vmap_vram (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vmap_pkg::mem_req_t                     req_i,
  output logic                                   clr_busy_o,
  output logic [2*vmap_pkg::ByteW-1:0]           rd_word_o
);

  logic [vmap_pkg::ByteW-1:0] lo_mem [vmap_pkg::WordCount];
  logic [vmap_pkg::ByteW-1:0] hi_mem [vmap_pkg::WordCount];

  logic [vmap_pkg::PhysW-1:0] clr_cnt_q, clr_cnt_d;
  logic                       clr_busy_q, clr_busy_d;
  logic [vmap_pkg::ByteW-1:0] rd_lo_q, rd_hi_q;

  logic [vmap_pkg::PhysW-1:0] wr_addr;
  logic [vmap_pkg::ByteW-1:0] wr_data;
  logic                       wr_lo_en, wr_hi_en;

  always_comb begin
    clr_cnt_d  = clr_cnt_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_cnt_d = clr_cnt_q + 1'b1;
      if (&clr_cnt_q) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    if (clr_busy_q) begin
      wr_addr  = clr_cnt_q;
      wr_data  = '0;
      wr_lo_en = 1'b1;
      wr_hi_en = 1'b1;
    end else begin
      wr_addr  = req_i.addr;
      wr_data  = req_i.wdata;
      wr_lo_en = req_i.wr_lo;
      wr_hi_en = req_i.wr_hi;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q  <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_cnt_q  <= clr_cnt_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_lo_en) begin
      lo_mem[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_lo_q <= lo_mem[req_i.addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_hi_en) begin
      hi_mem[wr_addr] <= wr_data;
    end
    if (req_i.rd_en) begin
      rd_hi_q <= hi_mem[req_i.addr];
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign rd_word_o  = {rd_hi_q, rd_lo_q};

endmodule
